@@ rtl/core/stp_pkg.sv @@
// Shared constants for the stereo point triangulation block.
package stp_pkg;
    localparam int unsigned CoordWidth = 16;
    localparam int unsigned ZWidth     = 15;
    localparam int unsigned CfgIdxW    = 3;
    localparam int unsigned DefIndexBits = 12;

    localparam logic [CfgIdxW-1:0] REG_FOCAL_X  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_FOCAL_Y  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_CENTER_U = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_CENTER_V = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_BASELINE = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_DEPTH_LIM = 3'd5;

    localparam logic [15:0] RST_FOCAL_X  = 16'd11502;
    localparam logic [15:0] RST_FOCAL_Y  = 16'd11502;
    localparam logic [15:0] RST_CENTER_U = 16'd9715;
    localparam logic [15:0] RST_CENTER_V = 16'd2963;
    localparam logic [15:0] RST_BASELINE = 16'd35389;
    localparam logic [14:0] RST_DEPTH_LIM = 15'd20480;

    typedef logic signed [CoordWidth:0] t_offset;
endpackage

@@ rtl/core/stp_div_cell.sv @@
// One restoring-division step: consume one dividend bit, emit one quotient bit.
module stp_div_cell #(
    parameter int unsigned W  = 16,
    parameter int unsigned Q  = 16,
    parameter int unsigned SB = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [W-1:0]  i_rem,
    input  logic [Q-1:0]  i_dvd,
    input  logic [W-1:0]  i_div,
    input  logic [Q-1:0]  i_quo,
    input  logic [SB-1:0] i_sb,
    output logic          o_vld,
    output logic [W-1:0]  o_rem,
    output logic [Q-1:0]  o_dvd,
    output logic [W-1:0]  o_div,
    output logic [Q-1:0]  o_quo,
    output logic [SB-1:0] o_sb
);
    logic [W:0]   w_trial;
    logic [W:0]   w_diff;
    logic         w_ge;
    logic [W-1:0] n_rem;

    assign w_trial = {i_rem, i_dvd[Q-1]};
    assign w_diff  = w_trial - {1'b0, i_div};
    assign w_ge    = (w_trial >= {1'b0, i_div});
    assign n_rem   = w_ge ? w_diff[W-1:0] : w_trial[W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_vld;
        end
        o_rem <= n_rem;
        o_dvd <= {i_dvd[Q-2:0], 1'b0};
        o_div <= i_div;
        o_quo <= {i_quo[Q-2:0], w_ge};
        o_sb  <= i_sb;
    end
endmodule

@@ rtl/core/stp_div_chain.sv @@
// Row of Q division cells; the quotient is complete at the output of the last cell.
module stp_div_chain #(
    parameter int unsigned W  = 16,
    parameter int unsigned Q  = 16,
    parameter int unsigned SB = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [W-1:0]  i_rem,
    input  logic [Q-1:0]  i_dvd,
    input  logic [W-1:0]  i_div,
    input  logic [SB-1:0] i_sb,
    output logic          o_vld,
    output logic [Q-1:0]  o_quo,
    output logic [SB-1:0] o_sb
);
    logic          w_vld [0:Q];
    logic [W-1:0]  w_rem [0:Q];
    logic [Q-1:0]  w_dvd [0:Q];
    logic [W-1:0]  w_div [0:Q];
    logic [Q-1:0]  w_quo [0:Q];
    logic [SB-1:0] w_sb  [0:Q];

    assign w_vld[0] = i_vld;
    assign w_rem[0] = i_rem;
    assign w_dvd[0] = i_dvd;
    assign w_div[0] = i_div;
    assign w_quo[0] = '0;
    assign w_sb[0]  = i_sb;

    for (genvar g = 0; g < Q; g++) begin : g_cell
        stp_div_cell #(.W(W), .Q(Q), .SB(SB)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_vld(w_vld[g]), .i_rem(w_rem[g]), .i_dvd(w_dvd[g]),
            .i_div(w_div[g]), .i_quo(w_quo[g]), .i_sb(w_sb[g]),
            .o_vld(w_vld[g+1]), .o_rem(w_rem[g+1]), .o_dvd(w_dvd[g+1]),
            .o_div(w_div[g+1]), .o_quo(w_quo[g+1]), .o_sb(w_sb[g+1])
        );
    end

    assign o_vld = w_vld[Q];
    assign o_quo = w_quo[Q];
    assign o_sb  = w_sb[Q];
endmodule

@@ rtl/core/stereo_point_triangulation_top.sv @@
// Stereo triangulation: disparity to depth and lateral coordinates, one point per cycle.
//
// Usage:
//   Input: pulse i_start with a matched keypoint pair (left u/v, right u, match
//   index). o_busy is always low, so a transaction is taken every cycle.
//   Output: o_strobe marks one result cycle carrying index, valid flag,
//   x/y in signed Q8.8 metres and z in unsigned Q7.8 metres; invalid points
//   report zero coordinates. Pipeline stages, each registered: capture,
//   disparity and focal*baseline product, a 15-cell depth divider chain,
//   the lateral products, a 16-cell lateral divider chain per axis, and
//   the output stage.
//   Throughput is one point per cycle; every divider cell hands its partial
//   remainder to the next cell each cycle.
//   Configuration: i_cfg_valid with i_cfg_index and i_cfg_data; o_cfg_ready
//   is always high. Write only while no point is in flight. Indexes past the
//   register list are dropped.
//   Reset (synchronous, active low) restores register defaults and empties
//   the pipeline. The receiver cannot stall; results are shown once.
module stereo_point_triangulation_top #(
    parameter int unsigned INDEX_BITS = stp_pkg::DefIndexBits
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [INDEX_BITS-1:0]         i_match_index,
    input  logic [stp_pkg::CoordWidth-1:0] i_left_u,
    input  logic [stp_pkg::CoordWidth-1:0] i_left_v,
    input  logic [stp_pkg::CoordWidth-1:0] i_right_u,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [stp_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    output logic                          o_strobe,
    output logic [INDEX_BITS-1:0]         o_point_index,
    output logic                          o_point_valid,
    output logic signed [15:0]            o_point_x,
    output logic signed [15:0]            o_point_y,
    output logic [stp_pkg::ZWidth-1:0]    o_point_z
);
    import stp_pkg::*;

    localparam int unsigned ZQ   = ZWidth;
    localparam int unsigned LQ   = 16;
    localparam int unsigned SBZ  = INDEX_BITS + 2 * (CoordWidth + 1) + 1;
    localparam int unsigned SBX  = INDEX_BITS + 1 + ZWidth + 2;
    localparam int unsigned SBY  = 2;
    localparam int unsigned LAT  = 2 + ZQ + 1 + LQ + 1;

    // configuration registers
    logic [15:0] r_fx, r_fy, r_cu, r_cv, r_base;
    logic [14:0] r_lim;
    logic [15:0] w_fx1, w_fy1;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx   <= RST_FOCAL_X;
            r_fy   <= RST_FOCAL_Y;
            r_cu   <= RST_CENTER_U;
            r_cv   <= RST_CENTER_V;
            r_base <= RST_BASELINE;
            r_lim  <= RST_DEPTH_LIM;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FOCAL_X:   r_fx   <= i_cfg_data;
                REG_FOCAL_Y:   r_fy   <= i_cfg_data;
                REG_CENTER_U:  r_cu   <= i_cfg_data;
                REG_CENTER_V:  r_cv   <= i_cfg_data;
                REG_BASELINE:  r_base <= i_cfg_data;
                REG_DEPTH_LIM: r_lim  <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // zero focal length acts as one in the lateral dividers
    assign w_fx1 = (r_fx == '0) ? 16'd1 : r_fx;
    assign w_fy1 = (r_fy == '0) ? 16'd1 : r_fy;

    // stage 0: capture
    logic                  r0_vld;
    logic [INDEX_BITS-1:0] r0_idx;
    logic [15:0]           r0_lu, r0_lv, r0_ru;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else begin
            r0_vld <= i_start;
        end
        r0_idx <= i_match_index;
        r0_lu  <= i_left_u;
        r0_lv  <= i_left_v;
        r0_ru  <= i_right_u;
    end

    // stage 1: disparity, focal*baseline, offsets
    logic                  r1_vld;
    logic [INDEX_BITS-1:0] r1_idx;
    logic [31:0]           r1_num;
    logic [15:0]           r1_disp;
    t_offset               r1_offx, r1_offy;
    logic [16:0]           w_disp;

    assign w_disp = {1'b0, r0_lu} - {1'b0, r0_ru};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= r0_vld;
        end
        r1_idx  <= r0_idx;
        r1_num  <= 32'(r_fx) * 32'(r_base);
        // clamp non-positive disparity to one LSB
        r1_disp <= (w_disp[16] || w_disp == '0) ? 16'd1 : w_disp[15:0];
        r1_offx <= t_offset'({1'b0, r0_lu}) - t_offset'({1'b0, r_cu});
        r1_offy <= t_offset'({1'b0, r0_lv}) - t_offset'({1'b0, r_cv});
    end

    // depth divider: (num >> 8) / disp, 15 quotient bits
    logic [15:0]     w_zrem0;
    logic            w_zovf;
    logic            wz_vld;
    logic [ZQ-1:0]   wz_quo;
    logic [SBZ-1:0]  wz_sb;
    logic [INDEX_BITS-1:0] z_idx;
    t_offset         z_offx, z_offy;
    logic            z_ovf;

    assign w_zrem0 = {7'd0, r1_num[31:23]};
    assign w_zovf  = (w_zrem0 >= r1_disp);

    stp_div_chain #(.W(16), .Q(ZQ), .SB(SBZ)) u_zdiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r1_vld),
        .i_rem(w_zrem0), .i_dvd(r1_num[22:8]), .i_div(r1_disp),
        .i_sb({r1_idx, r1_offx, r1_offy, w_zovf}),
        .o_vld(wz_vld), .o_quo(wz_quo), .o_sb(wz_sb)
    );

    assign {z_idx, z_offx, z_offy, z_ovf} = wz_sb;

    // stage m: lateral magnitudes times depth
    logic                  rm_vld, rm_ok, rm_negx, rm_negy;
    logic [INDEX_BITS-1:0] rm_idx;
    logic [ZWidth-1:0]     rm_z;
    logic [31:0]           rm_magx, rm_magy;
    logic [15:0]           w_absx, w_absy;
    logic [16:0]           w_negx, w_negy;

    assign w_negx = -z_offx;
    assign w_negy = -z_offy;
    assign w_absx = z_offx[CoordWidth] ? w_negx[15:0] : z_offx[15:0];
    assign w_absy = z_offy[CoordWidth] ? w_negy[15:0] : z_offy[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm_vld <= 1'b0;
        end else begin
            rm_vld <= wz_vld;
        end
        rm_idx  <= z_idx;
        rm_ok   <= !z_ovf && (wz_quo < r_lim);
        rm_z    <= wz_quo;
        rm_negx <= z_offx[CoordWidth];
        rm_negy <= z_offy[CoordWidth];
        rm_magx <= 32'(w_absx) * 32'(wz_quo);
        rm_magy <= 32'(w_absy) * 32'(wz_quo);
    end

    // lateral dividers, 16 quotient bits plus overflow flag
    logic            w_xovf, w_yovf;
    logic            wx_vld, wy_vld;
    logic [LQ-1:0]   wx_quo, wy_quo;
    logic [SBX-1:0]  wx_sb;
    logic [SBY-1:0]  wy_sb;
    logic [INDEX_BITS-1:0] x_idx;
    logic            x_ok, x_neg, x_ovf, y_neg, y_ovf;
    logic [ZWidth-1:0] x_z;

    assign w_xovf = (rm_magx[31:16] >= w_fx1);
    assign w_yovf = (rm_magy[31:16] >= w_fy1);

    stp_div_chain #(.W(16), .Q(LQ), .SB(SBX)) u_xdiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(rm_vld),
        .i_rem(rm_magx[31:16]), .i_dvd(rm_magx[15:0]), .i_div(w_fx1),
        .i_sb({rm_idx, rm_ok, rm_z, rm_negx, w_xovf}),
        .o_vld(wx_vld), .o_quo(wx_quo), .o_sb(wx_sb)
    );

    stp_div_chain #(.W(16), .Q(LQ), .SB(SBY)) u_ydiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(rm_vld),
        .i_rem(rm_magy[31:16]), .i_dvd(rm_magy[15:0]), .i_div(w_fy1),
        .i_sb({rm_negy, w_yovf}),
        .o_vld(wy_vld), .o_quo(wy_quo), .o_sb(wy_sb)
    );

    assign {x_idx, x_ok, x_z, x_neg, x_ovf} = wx_sb;
    assign {y_neg, y_ovf} = wy_sb;

    function automatic logic [15:0] sat_signed(input logic neg, input logic ovf,
                                               input logic [15:0] q);
        logic [15:0] res;
        if (neg) begin
            res = (ovf || q > 16'd32768) ? 16'h8000 : (16'd0 - q);
        end else begin
            res = (ovf || q > 16'd32767) ? 16'h7FFF : q;
        end
        return res;
    endfunction

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= wx_vld;
        end
        o_point_index <= x_idx;
        o_point_valid <= x_ok;
        o_point_x     <= x_ok ? sat_signed(x_neg, x_ovf, wx_quo) : '0;
        o_point_y     <= x_ok ? sat_signed(y_neg, y_ovf, wy_quo) : '0;
        o_point_z     <= x_ok ? x_z : '0;
    end

`ifndef SYNTHESIS
    a_strobe_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_start, LAT))
        else $error("strobe without matching accept");
    a_chains_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wx_vld == wy_vld)
        else $error("lateral chains out of step");
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_point_valid) |-> (o_point_x == '0 && o_point_y == '0
                                          && o_point_z == '0))
        else $error("invalid point carries coordinates");
    a_valid_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_point_valid) |-> (o_point_z < r_lim))
        else $error("valid point at or beyond depth limit");
`endif
endmodule
